// File: hw/rtl/mvcrc_pkg.sv
// Shared types, register indexes and the CRC table-entry function.
`timescale 1ns / 1ps
package mvcrc_pkg;

    localparam logic [1:0] REG_CRC_TYPE      = 2'd0;
    localparam logic [1:0] REG_INIT_VAL      = 2'd1;
    localparam logic [1:0] REG_XOR_OUT       = 2'd2;
    localparam logic [1:0] REG_RESULT_LE     = 2'd3;

    localparam logic [2:0] VAR_CRC8_07      = 3'd0;
    localparam logic [2:0] VAR_CRC16_8005   = 3'd1;
    localparam logic [2:0] VAR_CRC16_1021   = 3'd2;
    localparam logic [2:0] VAR_CRC32_MSB    = 3'd3;
    localparam logic [2:0] VAR_CRC32_REFL   = 3'd4;
    localparam logic [2:0] VAR_CRC16_002D   = 3'd5;

    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [2:0]  crc_type;
        logic [31:0] init_val;
        logic [31:0] xor_out;
        logic        result_little_endian;
    } cfg_t;

    function automatic logic [2:0] variant_of(input logic [2:0] t);
        logic [2:0] v;
        v = (t > VAR_CRC16_002D) ? VAR_CRC8_07 : t;
        return v;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] crc_entry(input logic [2:0] v, input logic [7:0] idx);
        logic [31:0] aligned;
        logic [31:0] c;
        unique case (v)
            VAR_CRC16_8005: aligned = 32'h8005_0000;
            VAR_CRC16_1021: aligned = 32'h1021_0000;
            VAR_CRC32_MSB:  aligned = 32'h04C1_1DB7;
            VAR_CRC16_002D: aligned = 32'h002D_0000;
            default:        aligned = 32'h0700_0000;
        endcase
        if (v == VAR_CRC32_REFL) begin
            c = {24'd0, idx};
            for (int j = 0; j < 8; j++) begin
                c = {1'b0, c[31:1]} ^ (c[0] ? 32'hEDB8_8320 : 32'd0);
            end
            return c;
        end else begin
            c = {idx, 24'd0};
            for (int j = 0; j < 8; j++) begin
                c = {c[30:0], 1'b0} ^ (c[31] ? aligned : 32'd0);
            end
            return swap32(c);
        end
    endfunction

endpackage

// File: hw/rtl/multi_variant_crc_byte_engine.sv
// Top level of the byte-wise multi-variant CRC engine.
//
//  Channel   Dir  Handshake             Payload
//  s_        in   s_tvalid/s_tready     tdata: data_byte; tuser: restart
//  m_        out  m_tvalid/m_tready     tdata: crc_value, final_value, res_len
//  cfg_      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One byte per cycle sustained while m_tready is high; each byte passes the input register, then the output register.
// The CRC register feeds back to itself through the eight-step table entry.
// aresetn is synchronous: it clears the CRC register, the configuration and valids.
// A stalled m_ side holds one result and one buffered input, then drops s_tready.
`timescale 1ns / 1ps
module multi_variant_crc_byte_engine
    import mvcrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] crc_value, [63:32] final_value, [66:64] res_len
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t       cfg;
    logic       in_valid;
    logic       in_take;
    logic [7:0] in_byte;
    logic       in_restart;

    mvcrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mvcrc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .in_valid   (in_valid),
        .in_take    (in_take),
        .in_byte    (in_byte),
        .in_restart (in_restart)
    );

    mvcrc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_take    (in_take),
        .in_byte    (in_byte),
        .in_restart (in_restart),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: hw/rtl/mvcrc_cfg_regs.sv
// Configuration register file written through the index/data channel.
`timescale 1ns / 1ps
module mvcrc_cfg_regs
    import mvcrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CRC_TYPE:      cfg_reg.crc_type <= cfg_data[2:0];
                REG_INIT_VAL:      cfg_reg.init_val <= cfg_data;
                REG_XOR_OUT:       cfg_reg.xor_out <= cfg_data;
                REG_RESULT_LE:     cfg_reg.result_little_endian <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// File: hw/rtl/mvcrc_in_stage.sv
// Input register holding one accepted byte and its restart flag.
`timescale 1ns / 1ps
module mvcrc_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [0:0] s_tuser,
    output logic       in_valid,
    input  logic       in_take,
    output logic [7:0] in_byte,
    output logic       in_restart
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       restart_reg;

    assign s_tready   = !valid_reg || in_take;
    assign in_valid   = valid_reg;
    assign in_byte    = byte_reg;
    assign in_restart = restart_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg    <= s_tdata;
            restart_reg <= s_tuser[0];
        end
    end

endmodule

// File: hw/rtl/mvcrc_core.sv
// CRC register update, result formatting and output register.
`timescale 1ns / 1ps
module mvcrc_core
    import mvcrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_take,
    input  logic [7:0]  in_byte,
    input  logic        in_restart,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        out_valid_reg;
    logic [31:0] res_reg;
    logic [31:0] fin_reg;
    logic [2:0]  len_reg;
    logic [2:0]  variant;
    logic [31:0] base;
    logic [31:0] res_next;
    logic [31:0] fin_next;
    logic [2:0]  len_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign in_take  = in_valid && out_free;
    assign variant  = variant_of(cfg.crc_type);
    assign base     = in_restart ? cfg.init_val : crc_reg;
    assign crc_next = crc_entry(variant, base[7:0] ^ in_byte) ^ {8'd0, base[31:8]};
    assign res_next = crc_next ^ cfg.xor_out;

    always_comb begin
        unique case (variant)
            VAR_CRC32_MSB, VAR_CRC32_REFL: begin
                len_next = LEN_FOUR;
                fin_next = cfg.result_little_endian ? swap32(res_next) : res_next;
            end
            VAR_CRC16_8005, VAR_CRC16_1021, VAR_CRC16_002D: begin
                len_next = LEN_TWO;
                fin_next = cfg.result_little_endian ?
                           {16'd0, res_next[7:0], res_next[15:8]} :
                           {16'd0, res_next[15:0]};
            end
            default: begin
                len_next = LEN_ONE;
                fin_next = {24'd0, res_next[7:0]};
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, len_reg, fin_reg, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_take) begin
                crc_reg <= crc_next;
            end
            if (out_free) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            res_reg <= res_next;
            fin_reg <= fin_next;
            len_reg <= len_next;
        end
    end

endmodule

// File: tb/multi_variant_crc_byte_engine_tb.sv
// Self-checking testbench for the byte-wise CRC engine across all variants and random settings.
`timescale 1ns / 1ps
module multi_variant_crc_byte_engine_tb;
    import mvcrc_pkg::*;

    typedef struct {
        logic [31:0] crc_value;
        logic [31:0] final_value;
        logic [2:0]  res_len;
    } crc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_CRC_TYPE;
    logic [31:0] cfg_data = 32'd0;

    logic [2:0]  model_type;
    logic [31:0] model_init;
    logic [31:0] model_xor;
    logic        model_le;
    logic [31:0] model_crc;

    crc_result_t pending_results[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_pending = 1'b0;
    int          hold_left = 0;

    multi_variant_crc_byte_engine i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [31:0] crc_table_word(input logic [2:0] variant,
                                                   input logic [7:0] index);
        logic [31:0] poly_top;
        logic [31:0] w;
        case (variant)
            VAR_CRC16_8005: poly_top = 32'h8005 << 16;
            VAR_CRC16_1021: poly_top = 32'h1021 << 16;
            VAR_CRC32_MSB:  poly_top = 32'h04C11DB7;
            VAR_CRC16_002D: poly_top = 32'h002D << 16;
            default:        poly_top = 32'h07 << 24;
        endcase
        if (variant == VAR_CRC32_REFL) begin
            w = {24'd0, index};
            for (int k = 0; k < 8; k++) begin
                w = (w >> 1) ^ (w[0] ? 32'hEDB88320 : 32'd0);
            end
            return w;
        end
        w = {index, 24'd0};
        for (int k = 0; k < 8; k++) begin
            w = (w << 1) ^ (w[31] ? poly_top : 32'd0);
        end
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Fold one accepted byte into the model register and queue the expected result.
    task automatic fold_byte_and_expect(input logic [7:0] data_byte, input logic restart);
        logic [2:0]  variant;
        logic [31:0] folded;
        crc_result_t r;
        variant = (model_type > VAR_CRC16_002D) ? VAR_CRC8_07 : model_type;
        if (restart) begin
            model_crc = model_init;
        end
        model_crc = crc_table_word(variant, model_crc[7:0] ^ data_byte) ^ (model_crc >> 8);
        folded = model_crc ^ model_xor;
        r.crc_value = folded;
        case (variant)
            VAR_CRC32_MSB, VAR_CRC32_REFL: begin
                r.res_len = LEN_FOUR;
                r.final_value = model_le ?
                    {folded[7:0], folded[15:8], folded[23:16], folded[31:24]} : folded;
            end
            VAR_CRC16_8005, VAR_CRC16_1021, VAR_CRC16_002D: begin
                r.res_len = LEN_TWO;
                r.final_value = model_le ? {16'd0, folded[7:0], folded[15:8]}
                                         : {16'd0, folded[15:0]};
            end
            default: begin
                r.res_len = LEN_ONE;
                r.final_value = {24'd0, folded[7:0]};
            end
        endcase
        pending_results.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] data_byte, input logic restart);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        fold_byte_and_expect(data_byte, restart);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_CRC_TYPE:      model_type = value[2:0];
            REG_INIT_VAL:      model_init = value;
            REG_XOR_OUT:       model_xor  = value;
            REG_RESULT_LE:     model_le   = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [2:0] crc_type, input logic [31:0] init_value,
                              input logic [31:0] xor_value, input logic little_endian);
        wait_drained();
        write_reg(REG_CRC_TYPE, {29'd0, crc_type});
        write_reg(REG_INIT_VAL, init_value);
        write_reg(REG_XOR_OUT, xor_value);
        write_reg(REG_RESULT_LE, {31'd0, little_endian});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_each_variant();
        for (int t = 0; t < 8; t++) begin
            set_config(t[2:0], (t % 2) ? 32'hFFFF_FFFF : 32'd0,
                       (t % 3 == 0) ? 32'hFFFF_FFFF : 32'd0, t[1]);
            send_byte(8'hFF, 1'b1);
            send_byte(8'h00, 1'b0);
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int item_total);
        int sent;
        int msg_len;
        logic restart;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_total) begin
            set_config(3'($urandom_range(0, 7)), pick_word(), pick_word(),
                       1'($urandom_range(0, 1)));
            for (int m = 0; m < 6 && sent < item_total; m++) begin
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
                for (int b = 0; b < msg_len; b++) begin
                    if (b == 0) begin
                        restart = ($urandom_range(0, 9) != 0);
                    end else begin
                        restart = ($urandom_range(0, 19) == 0);
                    end
                    send_byte(8'($urandom_range(0, 255)), restart);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(VAR_CRC32_MSB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        hold_pending = 1'b1;
        for (int b = 0; b < 30; b++) begin
            send_byte(8'($urandom_range(0, 255)), b == 0);
        end
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        set_config(VAR_CRC16_1021, 32'h0000_FFFF, 32'd0, 1'b0);
        for (int b = 0; b < 12; b++) begin
            send_byte(8'($urandom_range(0, 255)), b == 0);
        end
        wait_drained();
        for (int b = 0; b < 12; b++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_pending && hold_left == 0) begin
            hold_pending = 1'b0;
            hold_left = 300;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        crc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: m_tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.crc_value) begin
                    $error("crc_value mismatch: expected %h, actual %h",
                           want.crc_value, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[63:32] !== want.final_value) begin
                    $error("final_value mismatch: expected %h, actual %h",
                           want.final_value, m_tdata[63:32]);
                    mismatch_count++;
                end
                if (m_tdata[66:64] !== want.res_len) begin
                    $error("res_len mismatch: expected %0d, actual %0d",
                           want.res_len, m_tdata[66:64]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        model_type = VAR_CRC8_07;
        model_init = 32'd0;
        model_xor  = 32'd0;
        model_le   = 1'b0;
        model_crc  = 32'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_each_variant();
        test_backpressure();
        test_sender_pause();
        test_random_traffic(7, 84, 600);
        test_random_traffic(84, 7, 600);
        test_random_traffic(0, 0, 650);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
